// ===== hdl/ccdh_pkg.sv =====
// shared types and constants for the chain code direction histogram
`default_nettype none

package ccdh_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned DIR_COUNT = 8;
  localparam int unsigned DIR_W     = 3;
  localparam int unsigned FIELD_W   = 16;

  // freeman codes, north first, clockwise, y grows downward
  localparam logic [DIR_W-1:0] DIR_N  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_NE = 3'd1;
  localparam logic [DIR_W-1:0] DIR_E  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_SE = 3'd3;
  localparam logic [DIR_W-1:0] DIR_S  = 3'd4;
  localparam logic [DIR_W-1:0] DIR_SW = 3'd5;
  localparam logic [DIR_W-1:0] DIR_W_ = 3'd6;
  localparam logic [DIR_W-1:0] DIR_NW = 3'd7;

  // per-axis step class
  typedef enum logic [1:0] {
    AX_ZERO = 2'd0,
    AX_POS  = 2'd1,
    AX_NEG  = 2'd2,
    AX_FAR  = 2'd3
  } axis_t;

  typedef struct packed {
    logic             hit;
    logic [DIR_W-1:0] code;
  } dir_t;

  typedef enum logic [3:0] {
    ST_INIT  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_CLOSE = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  typedef enum logic {
    OP_INC   = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef struct packed {
    logic [DIR_W-1:0]   bin_index;
    logic [FIELD_W-1:0] bin_count;
    logic [FIELD_W-1:0] skipped_steps;
    logic               run_end;
  } out_word_t;

endpackage

`default_nettype wire

// ===== hdl/chain_code_direction_histogram.sv =====
// top level: 8-direction chain code histogram over contour points
//
// input channel (in_valid/in_ready): one contour point per word, x/y and a
//   final_point flag on the last point of the contour
// result channel (out_valid/out_ready): eight words per contour, bins 0..7
//   in order, each with the saturating skipped-step count; run_end on bin 7
// throughput: one point per cycle while a contour is open; the bins live in
//   an 8-entry memory with a registered read, updated read-modify-write with
//   one-deep write forwarding, so back-to-back steps to the same bin are fine
// a final point closes the contour: the closing step is counted in ST_CLOSE,
//   then the eight bins are read out and cleared one per cycle while the
//   output buffer has room; in_ready stays low until the last bin has been read
// receiver stall: a two-word output buffer holds results and the readout
//   pauses; nothing is lost or repeated
// reset: control clears, then a sweep zeroes all eight bin entries while
//   in_ready stays low
`default_nettype none

module chain_code_direction_histogram #(
  parameter int unsigned COORD_BITS = ccdh_pkg::COORD_BITS_DEF,
  parameter int unsigned COUNT_BITS = ccdh_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [COORD_BITS-1:0]         in_point_x,
  input  wire logic [COORD_BITS-1:0]         in_point_y,
  input  wire logic                          in_final_point,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [ccdh_pkg::DIR_W-1:0]    out_bin_index,
  output      logic [ccdh_pkg::FIELD_W-1:0]  out_bin_count,
  output      logic [ccdh_pkg::FIELD_W-1:0]  out_skipped_steps,
  output      logic                          out_run_end
);

  localparam int unsigned DW = ccdh_pkg::DIR_W;
  localparam logic [DW-1:0] LAST_BIN = DW'(ccdh_pkg::DIR_COUNT - 1);

  // classify one axis difference as -1, 0, +1 or out of reach
  function automatic ccdh_pkg::axis_t axis_class(input logic [COORD_BITS:0] d);
    ccdh_pkg::axis_t c;
    if (d == '0) begin
      c = ccdh_pkg::AX_ZERO;
    end else if (d == (COORD_BITS+1)'(1)) begin
      c = ccdh_pkg::AX_POS;
    end else if (d == '1) begin
      c = ccdh_pkg::AX_NEG;
    end else begin
      c = ccdh_pkg::AX_FAR;
    end
    return c;
  endfunction

  // direction of the step a -> b, hit low when not 8-adjacent
  function automatic ccdh_pkg::dir_t step_dir(input logic [COORD_BITS-1:0] ax,
                                              input logic [COORD_BITS-1:0] ay,
                                              input logic [COORD_BITS-1:0] bx,
                                              input logic [COORD_BITS-1:0] by);
    ccdh_pkg::axis_t cx;
    ccdh_pkg::axis_t cy;
    ccdh_pkg::dir_t  r;
    cx = axis_class({1'b0, bx} - {1'b0, ax});
    cy = axis_class({1'b0, by} - {1'b0, ay});
    r.hit  = 1'b1;
    r.code = ccdh_pkg::DIR_N;
    case (cy)
      ccdh_pkg::AX_NEG: begin
        case (cx)
          ccdh_pkg::AX_ZERO: r.code = ccdh_pkg::DIR_N;
          ccdh_pkg::AX_POS:  r.code = ccdh_pkg::DIR_NE;
          ccdh_pkg::AX_NEG:  r.code = ccdh_pkg::DIR_NW;
          default:           r.hit  = 1'b0;
        endcase
      end
      ccdh_pkg::AX_ZERO: begin
        case (cx)
          ccdh_pkg::AX_POS: r.code = ccdh_pkg::DIR_E;
          ccdh_pkg::AX_NEG: r.code = ccdh_pkg::DIR_W_;
          default:          r.hit  = 1'b0;
        endcase
      end
      ccdh_pkg::AX_POS: begin
        case (cx)
          ccdh_pkg::AX_POS:  r.code = ccdh_pkg::DIR_SE;
          ccdh_pkg::AX_ZERO: r.code = ccdh_pkg::DIR_S;
          ccdh_pkg::AX_NEG:  r.code = ccdh_pkg::DIR_SW;
          default:           r.hit  = 1'b0;
        endcase
      end
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + COUNT_BITS'(1);
  endfunction

  // control state
  ccdh_pkg::state_t         state_r, state_nxt;
  logic [DW:0]              k_r, k_nxt;          // sweep / readout counter
  logic                     have_first_r, have_first_nxt;
  logic [COUNT_BITS-1:0]    skip_r, skip_nxt;

  // contour points
  logic [COORD_BITS-1:0]    first_x_r, first_x_nxt;
  logic [COORD_BITS-1:0]    first_y_r, first_y_nxt;
  logic [COORD_BITS-1:0]    prev_x_r, prev_x_nxt;
  logic [COORD_BITS-1:0]    prev_y_r, prev_y_nxt;
  ccdh_pkg::dir_t           close_r, close_nxt;

  // update stage, the cycle after the memory read
  logic                     b_valid_r, b_valid_nxt;
  ccdh_pkg::op_t            b_op_r, b_op_nxt;
  logic [DW-1:0]            b_addr_r, b_addr_nxt;
  logic                     b_last_r, b_last_nxt;

  // bin memory and last-write forwarding
  logic [COUNT_BITS-1:0]    bin_mem [ccdh_pkg::DIR_COUNT];
  logic [COUNT_BITS-1:0]    rd_q_r;
  logic [DW-1:0]            mem_raddr;
  logic                     mem_we;
  logic [DW-1:0]            mem_waddr;
  logic [COUNT_BITS-1:0]    mem_wdata;
  logic                     wl_en_r;
  logic [DW-1:0]            wl_addr_r;
  logic [COUNT_BITS-1:0]    wl_data_r;
  logic [COUNT_BITS-1:0]    b_cur;

  // two-word output buffer, head drives the ports
  ccdh_pkg::out_word_t      e0_r, e0_nxt, e1_r, e1_nxt;
  logic [1:0]               cnt_r, cnt_nxt;
  ccdh_pkg::out_word_t      push_word;
  logic                     push, pop;
  logic [2:0]               occ;
  logic                     issue_ok;

  ccdh_pkg::dir_t           in_dir;
  ccdh_pkg::dir_t           in_close;
  logic [COORD_BITS-1:0]    cl_x, cl_y;
  logic                     accept;

  assign in_ready = (state_r == ccdh_pkg::ST_RUN);
  assign accept   = in_valid && in_ready;

  // step from the previous point, and the closing step from the first point
  assign in_dir   = step_dir(prev_x_r, prev_y_r, in_point_x, in_point_y);
  assign cl_x     = have_first_r ? first_x_r : in_point_x;
  assign cl_y     = have_first_r ? first_y_r : in_point_y;
  assign in_close = step_dir(cl_x, cl_y, in_point_x, in_point_y);

  // read address follows whatever the update stage will need next cycle
  always_comb begin
    case (state_r)
      ccdh_pkg::ST_CLOSE: mem_raddr = close_r.code;
      ccdh_pkg::ST_DRAIN: mem_raddr = k_r[DW-1:0];
      default:            mem_raddr = in_dir.code;
    endcase
  end

  // a write on the same edge as the read is not seen by the read
  assign b_cur = (wl_en_r && (wl_addr_r == b_addr_r)) ? wl_data_r : rd_q_r;

  always_comb begin
    if (state_r == ccdh_pkg::ST_INIT) begin
      mem_we    = 1'b1;
      mem_waddr = k_r[DW-1:0];
      mem_wdata = '0;
    end else begin
      mem_we    = b_valid_r;
      mem_waddr = b_addr_r;
      mem_wdata = (b_op_r == ccdh_pkg::OP_INC) ? sat_inc(b_cur) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[mem_waddr] <= mem_wdata;
    end
    rd_q_r <= bin_mem[mem_raddr];
  end

  // readout words
  assign push = b_valid_r && (b_op_r == ccdh_pkg::OP_DRAIN);
  assign pop  = out_valid && out_ready;

  always_comb begin
    push_word.bin_index     = b_addr_r;
    push_word.bin_count     = ccdh_pkg::FIELD_W'(b_cur);
    push_word.skipped_steps = ccdh_pkg::FIELD_W'(skip_r);
    push_word.run_end       = b_last_r;
  end

  // buffered words plus the one in flight must leave room for the next read
  assign occ      = {1'b0, cnt_r} + {2'b00, push};
  assign issue_ok = occ < (3'd2 + {2'b00, pop});

  always_comb begin
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    cnt_nxt = cnt_r;
    if (push && pop) begin
      if (cnt_r == 2'd1) begin
        e0_nxt = push_word;
      end else begin
        e0_nxt = e1_r;
        e1_nxt = push_word;
      end
    end else if (pop) begin
      e0_nxt  = e1_r;
      cnt_nxt = cnt_r - 2'd1;
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        e0_nxt = push_word;
      end else begin
        e1_nxt = push_word;
      end
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  assign out_valid         = (cnt_r != 2'd0);
  assign out_bin_index     = e0_r.bin_index;
  assign out_bin_count     = e0_r.bin_count;
  assign out_skipped_steps = e0_r.skipped_steps;
  assign out_run_end       = e0_r.run_end;

  // sequencing
  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    have_first_nxt = have_first_r;
    skip_nxt       = skip_r;
    first_x_nxt    = first_x_r;
    first_y_nxt    = first_y_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    close_nxt      = close_r;
    b_valid_nxt    = 1'b0;
    b_op_nxt       = ccdh_pkg::OP_INC;
    b_addr_nxt     = b_addr_r;
    b_last_nxt     = 1'b0;

    case (state_r)
      ccdh_pkg::ST_INIT: begin
        // zero sweep of the bin memory
        if (k_r[DW-1:0] == LAST_BIN) begin
          state_nxt = ccdh_pkg::ST_RUN;
          k_nxt     = '0;
        end else begin
          k_nxt = k_r + (DW+1)'(1);
        end
      end
      ccdh_pkg::ST_RUN: begin
        if (accept) begin
          prev_x_nxt = in_point_x;
          prev_y_nxt = in_point_y;
          if (!have_first_r) begin
            first_x_nxt = in_point_x;
            first_y_nxt = in_point_y;
          end else if (in_dir.hit) begin
            b_valid_nxt = 1'b1;
            b_addr_nxt  = in_dir.code;
          end else begin
            skip_nxt = sat_inc(skip_r);
          end
          if (in_final_point) begin
            have_first_nxt = 1'b0;
            close_nxt      = in_close;
            state_nxt      = ccdh_pkg::ST_CLOSE;
          end else begin
            have_first_nxt = 1'b1;
          end
        end
      end
      ccdh_pkg::ST_CLOSE: begin
        // closing step from the first point to the last
        if (close_r.hit) begin
          b_valid_nxt = 1'b1;
          b_addr_nxt  = close_r.code;
        end else begin
          skip_nxt = sat_inc(skip_r);
        end
        k_nxt     = '0;
        state_nxt = ccdh_pkg::ST_DRAIN;
      end
      ccdh_pkg::ST_DRAIN: begin
        if (!k_r[DW] && issue_ok) begin
          b_valid_nxt = 1'b1;
          b_op_nxt    = ccdh_pkg::OP_DRAIN;
          b_addr_nxt  = k_r[DW-1:0];
          b_last_nxt  = (k_r[DW-1:0] == LAST_BIN);
          k_nxt       = k_r + (DW+1)'(1);
        end
        if (push && b_last_r) begin
          skip_nxt  = '0;
          state_nxt = ccdh_pkg::ST_RUN;
        end
      end
      default: begin
        state_nxt = ccdh_pkg::ST_INIT;
        k_nxt     = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ccdh_pkg::ST_INIT;
      k_r          <= '0;
      have_first_r <= 1'b0;
      skip_r       <= '0;
      b_valid_r    <= 1'b0;
      wl_en_r      <= 1'b0;
      cnt_r        <= 2'd0;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      have_first_r <= have_first_nxt;
      skip_r       <= skip_nxt;
      b_valid_r    <= b_valid_nxt;
      wl_en_r      <= mem_we;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_x_r <= first_x_nxt;
    first_y_r <= first_y_nxt;
    prev_x_r  <= prev_x_nxt;
    prev_y_r  <= prev_y_nxt;
    close_r   <= close_nxt;
    b_op_r    <= b_op_nxt;
    b_addr_r  <= b_addr_nxt;
    b_last_r  <= b_last_nxt;
    wl_addr_r <= mem_waddr;
    wl_data_r <= mem_wdata;
    e0_r      <= e0_nxt;
    e1_r      <= e1_nxt;
  end

endmodule

`default_nettype wire

// ===== test/chain_code_direction_histogram_tb.sv =====
// self-checking testbench for the chain code direction histogram: contours in, bin words checked
`timescale 1ns / 100ps

module chain_code_direction_histogram_tb;

  localparam int unsigned XY_W = ccdh_pkg::COORD_BITS_DEF;
  localparam int unsigned DW   = ccdh_pkg::DIR_W;
  localparam int unsigned FW   = ccdh_pkg::FIELD_W;
  localparam int unsigned NDIR = ccdh_pkg::DIR_COUNT;
  localparam logic [FW-1:0] COUNT_MAX = '1;
  // rough size of the random part, in points
  localparam int unsigned RANDOM_POINTS = 456;
  // cycles left after the last bin word, well past the readout time
  localparam int unsigned SETTLE_CYCLES = 16;

  // one contour point as it waits for the driver, with its idle gap in front
  typedef struct packed {
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
    logic            last;
    logic [7:0]      gap;
  } point_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [XY_W-1:0]      in_point_x = '0;
  logic [XY_W-1:0]      in_point_y = '0;
  logic                 in_final_point = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DW-1:0]        out_bin_index;
  logic [FW-1:0]        out_bin_count;
  logic [FW-1:0]        out_skipped_steps;
  logic                 out_run_end;

  chain_code_direction_histogram u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .in_final_point    (in_final_point),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_bin_index     (out_bin_index),
    .out_bin_count     (out_bin_count),
    .out_skipped_steps (out_skipped_steps),
    .out_run_end       (out_run_end)
  );

  always #1 clk = ~clk;

  point_t               point_q[$];       // points not yet offered to the block
  ccdh_pkg::out_word_t  bin_expect_q[$];  // bin words the open contours still owe

  int unsigned err_cnt = 0;
  int unsigned points_sent = 0;
  int unsigned contours_closed = 0;
  int unsigned words_checked = 0;

  // ---------------------------------------------------------------------------
  // histogram predictor: its own copy of the contour state
  // ---------------------------------------------------------------------------
  logic [XY_W-1:0]    start_x, start_y;   // first point of the open contour
  logic [XY_W-1:0]    tail_x, tail_y;     // most recent point
  logic               contour_open;
  logic [FW-1:0]      dir_tally [NDIR];
  logic [FW-1:0]      skip_tally;

  task automatic clear_contour();
    start_x = '0;
    start_y = '0;
    tail_x = '0;
    tail_y = '0;
    contour_open = 1'b0;
    for (int k = 0; k < NDIR; k++) dir_tally[k] = '0;
    skip_tally = '0;
  endtask

  // freeman code of a step; hit is low when the points are not 8-neighbors
  function automatic ccdh_pkg::dir_t freeman_step(input logic [XY_W-1:0] ax, ay, bx, by);
    int             dx;
    int             dy;
    ccdh_pkg::dir_t d;
    dx = int'(bx) - int'(ax);
    dy = int'(by) - int'(ay);
    d.hit = 1'b1;
    d.code = ccdh_pkg::DIR_N;
    if (dx == 0 && dy == -1) d.code = ccdh_pkg::DIR_N;
    else if (dx == 1 && dy == -1) d.code = ccdh_pkg::DIR_NE;
    else if (dx == 1 && dy == 0) d.code = ccdh_pkg::DIR_E;
    else if (dx == 1 && dy == 1) d.code = ccdh_pkg::DIR_SE;
    else if (dx == 0 && dy == 1) d.code = ccdh_pkg::DIR_S;
    else if (dx == -1 && dy == 1) d.code = ccdh_pkg::DIR_SW;
    else if (dx == -1 && dy == 0) d.code = ccdh_pkg::DIR_W_;
    else if (dx == -1 && dy == -1) d.code = ccdh_pkg::DIR_NW;
    else d.hit = 1'b0;
    return d;
  endfunction

  // saturating count of one step, into its bin or into the skipped count
  task automatic count_step(input logic [XY_W-1:0] ax, ay, bx, by);
    ccdh_pkg::dir_t d;
    d = freeman_step(ax, ay, bx, by);
    if (d.hit) begin
      if (dir_tally[d.code] != COUNT_MAX) dir_tally[d.code]++;
    end else if (skip_tally != COUNT_MAX) begin
      skip_tally++;
    end
  endtask

  // fold one accepted point in; a final point closes the loop and owes 8 words
  task automatic take_point(input point_t p);
    ccdh_pkg::out_word_t w;
    if (!contour_open) begin
      start_x = p.x;
      start_y = p.y;
      contour_open = 1'b1;
    end else begin
      count_step(tail_x, tail_y, p.x, p.y);
    end
    tail_x = p.x;
    tail_y = p.y;
    if (p.last) begin
      // closing step runs from the first point to this one
      count_step(start_x, start_y, p.x, p.y);
      for (int k = 0; k < NDIR; k++) begin
        w.bin_index = DW'(k);
        w.bin_count = dir_tally[k];
        w.skipped_steps = skip_tally;
        w.run_end = (k == NDIR - 1);
        bin_expect_q.push_back(w);
      end
      clear_contour();
      contours_closed++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // idle length drawn from three ranges: mostly the lowest, now and then the highest
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  task automatic queue_point(input logic [XY_W-1:0] x, y, input logic last,
                             input logic quiet);
    point_t p;
    p.x = x;
    p.y = y;
    p.last = last;
    p.gap = (quiet || $urandom_range(0, 1) == 0) ? 8'd0 : 8'(idle_len());
    point_q.push_back(p);
  endtask

  // one 8-neighbor move, wrapping at the coordinate width
  task automatic move_toward(input logic [DW-1:0] code,
                             inout logic [XY_W-1:0] x, y);
    int dx;
    int dy;
    dx = 0;
    dy = 0;
    case (code)
      ccdh_pkg::DIR_N:  dy = -1;
      ccdh_pkg::DIR_NE: begin dx = 1;  dy = -1; end
      ccdh_pkg::DIR_E:  dx = 1;
      ccdh_pkg::DIR_SE: begin dx = 1;  dy = 1;  end
      ccdh_pkg::DIR_S:  dy = 1;
      ccdh_pkg::DIR_SW: begin dx = -1; dy = 1;  end
      ccdh_pkg::DIR_W_: dx = -1;
      default: begin dx = -1; dy = -1; end
    endcase
    x = XY_W'(int'(x) + dx);
    y = XY_W'(int'(y) + dy);
  endtask

  function automatic logic [XY_W-1:0] edge_coord();
    return ($urandom_range(0, 1) == 0) ? XY_W'($urandom_range(0, 1))
                                      : XY_W'($urandom_range(4094, 4095));
  endfunction

  // ---------------------------------------------------------------------------
  // point driver: offers queued words, predicts each one as it is taken
  // ---------------------------------------------------------------------------
  point_t      cur_point;
  int unsigned hold_cnt = 0;

  always @(posedge clk) begin : point_driver
    logic busy;
    busy = in_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (in_valid && in_ready) begin
        take_point(cur_point);
        points_sent++;
        busy = 1'b0;
      end
      // valid only drops when the word went through and no next one is ready to go
      if (!busy) begin
        if (point_q.size() != 0 && hold_cnt >= point_q[0].gap) begin
          cur_point = point_q.pop_front();
          hold_cnt = 0;
          in_point_x <= cur_point.x;
          in_point_y <= cur_point.y;
          in_final_point <= cur_point.last;
          in_valid <= 1'b1;
        end else begin
          if (point_q.size() != 0) hold_cnt++;
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // bin monitor: random receiver stalls, compares each word with the oldest owed
  // ---------------------------------------------------------------------------
  int unsigned stall_cnt = 0;
  int unsigned calm_cnt = 0;

  always @(posedge clk) begin : bin_monitor
    ccdh_pkg::out_word_t got;
    ccdh_pkg::out_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.bin_index = out_bin_index;
        got.bin_count = out_bin_count;
        got.skipped_steps = out_skipped_steps;
        got.run_end = out_run_end;
        words_checked++;
        if (bin_expect_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unowed bin word: index %0d count %0d skipped %0d end %0b",
                     $realtime, got.bin_index, got.bin_count, got.skipped_steps,
                     got.run_end);
        end else begin
          want = bin_expect_q.pop_front();
          if (got.bin_index != want.bin_index || got.bin_count != want.bin_count ||
              got.skipped_steps != want.skipped_steps || got.run_end != want.run_end) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: bin word mismatch (exp/got): index %0d/%0d count %0d/%0d",
                       $realtime, want.bin_index, got.bin_index, want.bin_count,
                       got.bin_count, " skipped %0d/%0d end %0b/%0b",
                       want.skipped_steps, got.skipped_steps, want.run_end, got.run_end);
          end
        end
      end
      // stalls of random length, with quiet stretches where ready stays high
      if (stall_cnt != 0) begin
        stall_cnt--;
        out_ready <= 1'b0;
      end else begin
        if (calm_cnt != 0) calm_cnt--;
        else if ($urandom_range(0, 299) == 0) calm_cnt = $urandom_range(100, 300);
        else if ($urandom_range(0, 99) < 25) stall_cnt = idle_len();
        out_ready <= (stall_cnt == 0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [XY_W-1:0] x, y, x0, y0;
    logic            quiet;
    int unsigned     made, len, r;
    made = 0;
    clear_contour();

    // single-point contours at both corners: closing step is zero, so skipped
    queue_point(12'd0, 12'd0, 1'b1, 1'b0);
    queue_point(12'd4095, 12'd4095, 1'b1, 1'b0);

    // all eight directions once, then a zero step and two far jumps
    x = 12'd2048;
    y = 12'd2048;
    queue_point(x, y, 1'b0, 1'b0);
    for (int k = 0; k < NDIR; k++) begin
      move_toward(DW'(k), x, y);
      queue_point(x, y, 1'b0, 1'b0);
    end
    queue_point(x, y, 1'b0, 1'b0);
    queue_point(12'd0, 12'd4095, 1'b0, 1'b0);
    queue_point(12'd2048, 12'd2048, 1'b1, 1'b0);

    // steps across the coordinate edge are far, not adjacent
    queue_point(12'd0, 12'd0, 1'b0, 1'b0);
    queue_point(12'd4095, 12'd0, 1'b0, 1'b0);
    queue_point(12'd0, 12'd4095, 1'b1, 1'b0);

    // closing step lands in a bin
    queue_point(12'd4095, 12'd1, 1'b0, 1'b0);
    queue_point(12'd4095, 12'd0, 1'b0, 1'b0);
    queue_point(12'd4094, 12'd0, 1'b1, 1'b0);
    queue_point(12'd0, 12'd4095, 1'b0, 1'b0);
    queue_point(12'd1, 12'd4094, 1'b1, 1'b0);

    // random contours: mostly neighbor steps, some zero steps and jumps
    while (made < RANDOM_POINTS) begin
      quiet = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      if ($urandom_range(0, 3) == 0) begin
        x0 = edge_coord();
        y0 = edge_coord();
      end else begin
        x0 = XY_W'($urandom_range(0, 4095));
        y0 = XY_W'($urandom_range(0, 4095));
      end
      x = x0;
      y = y0;
      for (int i = 0; i < len; i++) begin
        if (i != 0) begin
          if (i == len - 1 && $urandom_range(0, 2) == 0) begin
            // end next to the start so the closing step counts
            x = x0;
            y = y0;
            move_toward(DW'($urandom_range(0, 7)), x, y);
          end else begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
              move_toward(DW'($urandom_range(0, 7)), x, y);
            end else if (r < 88) begin
              // repeat the point: zero step
            end else if (r < 94) begin
              x = XY_W'($urandom_range(0, 4095));
              y = XY_W'($urandom_range(0, 4095));
            end else begin
              x = x + XY_W'(2);
            end
          end
        end
        queue_point(x, y, i == len - 1, quiet);
        made++;
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (point_q.size() != 0 || in_valid) @(posedge clk);
    while (bin_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d points in %0d contours, %0d bin words checked, %0d mismatches",
             points_sent, contours_closed, words_checked, err_cnt);
    $display("including edge wraps, zero and far steps, and single-point contours");
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
